// ----- hdl/tsaq_pkg.sv -----
// shared types and constants for the tamper sensor alarm qualifier
// used by tsaq_engine and tamper_sensor_alarm_qualifier_core; no dependencies

package tsaq_pkg;

  localparam int InDataWidth  = 24;
  localparam int OutDataWidth = 16;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 16;

  // register indexes on the config port
  localparam logic [CfgIdxWidth-1:0] RegFirstTouch    = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegSecondTouch   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegTouchWindow   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegPosEnable     = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegPosQualify    = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegPosHold       = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegBatteryThresh = 3'd6;

  // register reset values
  localparam logic [7:0]  FirstTouchReset    = 8'd1;
  localparam logic [7:0]  SecondTouchReset   = 8'd1;
  localparam logic [15:0] TouchWindowReset   = 16'd4000;
  localparam logic [7:0]  PosQualifyReset    = 8'd10;
  localparam logic [15:0] PosHoldReset       = 16'd4000;
  localparam logic [9:0]  BatteryThreshReset = 10'h100;

  typedef struct packed {
    logic [7:0]  first_touch_ticks;
    logic [7:0]  second_touch_ticks;
    logic [15:0] touch_window_ticks;
    logic        position_enable;
    logic [7:0]  position_qualify_ticks;
    logic [15:0] position_hold_ticks;
    logic [9:0]  battery_low_threshold;
  } cfg_t;

  typedef struct packed {
    logic       sensor_enable;
    logic       touch_pin;
    logic       horizontal_pin;
    logic       alarm_in_progress;
    logic       flashing_busy;
    logic       transmitter_enable;
    logic       lock_wire_pin;
    logic [9:0] battery_level;
    logic       raised_pin;
    logic       fell_pin;
  } item_t;

  typedef struct packed {
    logic [1:0] id_prompt_requests;
    logic       learn_prompt_request;
    logic       stolen_alarm_start;
    logic       wire_restored;
    logic       battery_removed;
    logic       is_raised;
    logic       is_fallen;
    logic       raised_or_fell;
    logic       armed_stage;
  } result_t;

endpackage

// ----- hdl/tamper_sensor_alarm_qualifier_core.sv -----
// top level of the tamper sensor alarm qualifier: stream ports, config registers,
// result register; depends on tsaq_pkg and tsaq_engine
//
// Each input item is one timer tick with the raw tamper pins; each item gives exactly one
// result item. An item is taken every clock cycle while the result register is free or is
// being drained in the same cycle: the tick state updates in a single combinational pass
// between the input handshake and the result register, which captures the result of each
// accepted item. Config registers are written through the cfg port, which is always ready;
// indexes beyond the register list are ignored.

module tamper_sensor_alarm_qualifier_core (
  input  logic                                clk,
  input  logic                                rst,
  // sensor_enable, touch_pin, horizontal_pin, alarm_in_progress, flashing_busy,
  // transmitter_enable, lock_wire_pin, battery_level[9:0], raised_pin, fell_pin, zero pad
  input  logic [tsaq_pkg::InDataWidth-1:0]    s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // id_prompt_requests[1:0], learn_prompt_request, stolen_alarm_start, wire_restored,
  // battery_removed, is_raised, is_fallen, raised_or_fell, armed_stage, zero pad
  output logic [tsaq_pkg::OutDataWidth-1:0]   m_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsaq_pkg::CfgIdxWidth-1:0]    cfg_index,
  input  logic [tsaq_pkg::CfgDataWidth-1:0]   cfg_data
);
  import tsaq_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t result;
  logic    in_accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_touch_ticks      <= FirstTouchReset;
      cfg.second_touch_ticks     <= SecondTouchReset;
      cfg.touch_window_ticks     <= TouchWindowReset;
      cfg.position_enable        <= 1'b0;
      cfg.position_qualify_ticks <= PosQualifyReset;
      cfg.position_hold_ticks    <= PosHoldReset;
      cfg.battery_low_threshold  <= BatteryThreshReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegFirstTouch:    cfg.first_touch_ticks      <= cfg_data[7:0];
        RegSecondTouch:   cfg.second_touch_ticks     <= cfg_data[7:0];
        RegTouchWindow:   cfg.touch_window_ticks     <= cfg_data;
        RegPosEnable:     cfg.position_enable        <= cfg_data[0];
        RegPosQualify:    cfg.position_qualify_ticks <= cfg_data[7:0];
        RegPosHold:       cfg.position_hold_ticks    <= cfg_data;
        RegBatteryThresh: cfg.battery_low_threshold  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    item.sensor_enable      = s_tdata[0];
    item.touch_pin          = s_tdata[1];
    item.horizontal_pin     = s_tdata[2];
    item.alarm_in_progress  = s_tdata[3];
    item.flashing_busy      = s_tdata[4];
    item.transmitter_enable = s_tdata[5];
    item.lock_wire_pin      = s_tdata[6];
    item.battery_level      = s_tdata[16:7];
    item.raised_pin         = s_tdata[17];
    item.fell_pin           = s_tdata[18];
  end

  tsaq_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (in_accept),
    .cfg    (cfg),
    .item   (item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      m_tdata <= {6'd0, result.armed_stage, result.raised_or_fell, result.is_fallen,
                  result.is_raised, result.battery_removed, result.wire_restored,
                  result.stolen_alarm_start, result.learn_prompt_request,
                  result.id_prompt_requests};
    end
  end

endmodule

// ----- hdl/tsaq_engine.sv -----
// per-tick state update of the touch machine, lock wire, battery and position checks
// depends on tsaq_pkg; state advances on each accepted item, result is combinational

module tsaq_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  tsaq_pkg::cfg_t   cfg,
  input  tsaq_pkg::item_t  item,
  output tsaq_pkg::result_t result
);
  import tsaq_pkg::*;

  logic        stage, stage_next;
  logic [7:0]  first_touch_count, first_touch_count_next;
  logic [7:0]  second_touch_count, second_touch_count_next;
  logic [15:0] window_count, window_count_next;
  logic        wire_cut_mark, wire_cut_mark_next;
  logic        battery_flag, battery_flag_next;
  logic [7:0]  raise_count, raise_count_next;
  logic [7:0]  fall_count, fall_count_next;
  logic        raised_mark, raised_mark_next;
  logic        fallen_flag, fallen_flag_next;
  logic        event_flag, event_flag_next;
  logic        event_seen_once, event_seen_once_next;
  logic [15:0] hold_count, hold_count_next;

  logic [7:0]  first_inc, second_inc, raise_inc, fall_inc;
  logic [15:0] window_inc, hold_inc;
  logic        touched;
  logic [1:0]  id_req;
  logic        learn, stolen, restored;

  assign first_inc  = first_touch_count + 8'd1;
  assign second_inc = second_touch_count + 8'd1;
  assign window_inc = window_count + 16'd1;
  assign raise_inc  = raise_count + 8'd1;
  assign fall_inc   = fall_count + 8'd1;
  assign touched    = !item.touch_pin || !item.horizontal_pin;

  always_comb begin
    stage_next              = stage;
    first_touch_count_next  = first_touch_count;
    second_touch_count_next = second_touch_count;
    window_count_next       = window_count;
    wire_cut_mark_next      = wire_cut_mark;
    battery_flag_next       = battery_flag;
    raise_count_next        = raise_count;
    fall_count_next         = fall_count;
    raised_mark_next        = raised_mark;
    fallen_flag_next        = fallen_flag;
    event_flag_next         = event_flag;
    event_seen_once_next    = event_seen_once;
    hold_count_next         = hold_count;
    hold_inc                = hold_count + 16'd1;
    id_req                  = 2'd0;
    learn                   = 1'b0;
    stolen                  = 1'b0;
    restored                = 1'b0;

    if (item.sensor_enable) begin
      if (!stage) begin
        if (touched && !item.alarm_in_progress && !item.flashing_busy &&
            item.transmitter_enable) begin
          if (first_inc >= cfg.first_touch_ticks) begin
            first_touch_count_next = 8'd0;
            stage_next             = 1'b1;
            id_req                 = 2'd1;
          end else begin
            first_touch_count_next = first_inc;
          end
        end else begin
          first_touch_count_next = 8'd0;
        end
      end else begin
        if (touched) begin
          if (second_inc >= cfg.second_touch_ticks) begin
            second_touch_count_next = 8'd0;
            stage_next              = 1'b0;
            learn                   = 1'b1;
          end else begin
            second_touch_count_next = second_inc;
          end
        end else begin
          second_touch_count_next = 8'd0;
        end
        // window keeps running even on the tick the second touch lands
        if (window_inc >= cfg.touch_window_ticks) begin
          stage_next              = 1'b0;
          first_touch_count_next  = 8'd0;
          second_touch_count_next = 8'd0;
          window_count_next       = 16'd0;
        end else begin
          window_count_next = window_inc;
        end
      end

      if (!item.lock_wire_pin) begin
        stolen             = 1'b1;
        wire_cut_mark_next = 1'b1;
      end else if (wire_cut_mark) begin
        restored           = 1'b1;
        wire_cut_mark_next = 1'b0;
        id_req             = id_req + 2'd1;
      end

      battery_flag_next = item.battery_level < cfg.battery_low_threshold;
    end

    // raised pin handled before fell pin, fell wins on shared flags
    if (cfg.position_enable) begin
      if (!item.raised_pin) begin
        raise_count_next = raise_inc;
        if (raise_inc == cfg.position_qualify_ticks) begin
          raised_mark_next = 1'b1;
          fallen_flag_next = 1'b0;
          if (!event_seen_once) event_flag_next = 1'b1;
        end
      end else begin
        raised_mark_next = 1'b0;
        raise_count_next = 8'd0;
        event_flag_next  = 1'b0;
      end
      if (!item.fell_pin) begin
        fall_count_next = fall_inc;
        if (fall_inc == cfg.position_qualify_ticks) begin
          fallen_flag_next = 1'b1;
          raised_mark_next = 1'b0;
          if (!event_seen_once) event_flag_next = 1'b1;
        end
      end else begin
        fallen_flag_next = 1'b0;
        fall_count_next  = 8'd0;
        event_flag_next  = 1'b0;
      end
    end

    if (event_flag_next) begin
      if (hold_inc >= cfg.position_hold_ticks) begin
        event_flag_next         = 1'b0;
        hold_count_next         = 16'd0;
        event_seen_once_next    = 1'b1;
        stage_next              = 1'b0;
        first_touch_count_next  = 8'd0;
        second_touch_count_next = 8'd0;
        window_count_next       = 16'd0;
      end else begin
        hold_count_next = hold_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage              <= 1'b0;
      first_touch_count  <= 8'd0;
      second_touch_count <= 8'd0;
      window_count       <= 16'd0;
      wire_cut_mark      <= 1'b0;
      battery_flag       <= 1'b0;
      raise_count        <= 8'd0;
      fall_count         <= 8'd0;
      raised_mark        <= 1'b0;
      fallen_flag        <= 1'b0;
      event_flag         <= 1'b0;
      event_seen_once    <= 1'b0;
      hold_count         <= 16'd0;
    end else if (step) begin
      stage              <= stage_next;
      first_touch_count  <= first_touch_count_next;
      second_touch_count <= second_touch_count_next;
      window_count       <= window_count_next;
      wire_cut_mark      <= wire_cut_mark_next;
      battery_flag       <= battery_flag_next;
      raise_count        <= raise_count_next;
      fall_count         <= fall_count_next;
      raised_mark        <= raised_mark_next;
      fallen_flag        <= fallen_flag_next;
      event_flag         <= event_flag_next;
      event_seen_once    <= event_seen_once_next;
      hold_count         <= hold_count_next;
    end
  end

  always_comb begin
    result.id_prompt_requests   = id_req;
    result.learn_prompt_request = learn;
    result.stolen_alarm_start   = stolen;
    result.wire_restored        = restored;
    result.battery_removed      = battery_flag_next;
    result.is_raised            = raised_mark_next;
    result.is_fallen            = fallen_flag_next;
    result.raised_or_fell       = event_flag_next;
    result.armed_stage          = stage_next;
  end

endmodule

// ----- test/tamper_sensor_alarm_qualifier_core_tb.sv -----
// self-checking testbench for tamper_sensor_alarm_qualifier_core: tick items, per-tick results
// and register writes, checked against an in-bench predictor; depends on tsaq_pkg and the core

module tamper_sensor_alarm_qualifier_core_tb;
  import tsaq_pkg::*;

  localparam logic [CfgIdxWidth-1:0] RegNoSuch = 3'd7;
  localparam int WatchdogLimit = 2000;
  localparam int MaxReported = 10;

  typedef struct {
    bit        armed;
    bit [7:0]  first_cnt;
    bit [7:0]  second_cnt;
    bit [15:0] window_cnt;
    bit        wire_cut;
    bit        batt_low;
    bit [7:0]  raise_cnt;
    bit [7:0]  fall_cnt;
    bit        raised;
    bit        fallen;
    bit        event_pending;
    bit        event_done;
    bit [15:0] hold_cnt;
  } qual_state_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  // sensor_enable, touch_pin, horizontal_pin, alarm_in_progress, flashing_busy,
  // transmitter_enable, lock_wire_pin, battery_level[9:0], raised_pin, fell_pin, zero pad
  logic [InDataWidth-1:0]  s_tdata = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  // id_prompt_requests[1:0], learn_prompt_request, stolen_alarm_start, wire_restored,
  // battery_removed, is_raised, is_fallen, raised_or_fell, armed_stage, zero pad
  logic [OutDataWidth-1:0] m_tdata;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIdxWidth-1:0]  cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  cfg_t        regs;
  qual_state_t st;
  item_t       pending_ticks[$];
  result_t     expected_results[$];
  item_t       in_flight;

  int ticks_queued = 0;
  int results_checked = 0;
  int mismatches = 0;
  int reg_writes = 0;
  int id_requests = 0;
  int learn_requests = 0;
  int hold_timeouts = 0;
  int idle_cycles = 0;

  // stimulus shaping: runs of touches, cuts and low position pins
  int touch_run = 0;
  int raise_run = 0;
  int fall_run = 0;
  int cut_run = 0;

  int  gap_left = 0;
  int  burst_left = 0;
  bit  draining = 1'b0;
  int  stall_mode = 0;
  int  stall_phase = 0;

  tamper_sensor_alarm_qualifier_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void clear_touch_machine();
    st.armed = 1'b0;
    st.first_cnt = '0;
    st.second_cnt = '0;
    st.window_cnt = '0;
  endfunction

  // advances the qualifier state by one tick and returns the result it gives
  function automatic result_t qualify_tick(item_t t);
    result_t r;
    bit touched;
    r = '0;
    touched = !t.touch_pin || !t.horizontal_pin;
    if (t.sensor_enable) begin
      if (!st.armed) begin
        if (touched && !t.alarm_in_progress && !t.flashing_busy && t.transmitter_enable) begin
          st.first_cnt = st.first_cnt + 8'd1;
          if (st.first_cnt >= regs.first_touch_ticks) begin
            st.first_cnt = '0;
            st.armed = 1'b1;
            r.id_prompt_requests = r.id_prompt_requests + 2'd1;
          end
        end else begin
          st.first_cnt = '0;
        end
      end else begin
        if (touched) begin
          st.second_cnt = st.second_cnt + 8'd1;
          if (st.second_cnt >= regs.second_touch_ticks) begin
            st.second_cnt = '0;
            st.armed = 1'b0;
            r.learn_prompt_request = 1'b1;
          end
        end else begin
          st.second_cnt = '0;
        end
        // the window keeps running even on the tick the second touch lands
        st.window_cnt = st.window_cnt + 16'd1;
        if (st.window_cnt >= regs.touch_window_ticks) clear_touch_machine();
      end

      if (!t.lock_wire_pin) begin
        r.stolen_alarm_start = 1'b1;
        st.wire_cut = 1'b1;
      end else if (st.wire_cut) begin
        r.wire_restored = 1'b1;
        st.wire_cut = 1'b0;
        r.id_prompt_requests = r.id_prompt_requests + 2'd1;
      end

      st.batt_low = t.battery_level < regs.battery_low_threshold;
    end

    if (regs.position_enable) begin
      if (!t.raised_pin) begin
        st.raise_cnt = st.raise_cnt + 8'd1;
        if (st.raise_cnt == regs.position_qualify_ticks) begin
          st.raised = 1'b1;
          st.fallen = 1'b0;
          if (!st.event_done) st.event_pending = 1'b1;
        end
      end else begin
        st.raised = 1'b0;
        st.raise_cnt = '0;
        st.event_pending = 1'b0;
      end
      if (!t.fell_pin) begin
        st.fall_cnt = st.fall_cnt + 8'd1;
        if (st.fall_cnt == regs.position_qualify_ticks) begin
          st.fallen = 1'b1;
          st.raised = 1'b0;
          if (!st.event_done) st.event_pending = 1'b1;
        end
      end else begin
        st.fallen = 1'b0;
        st.fall_cnt = '0;
        st.event_pending = 1'b0;
      end
    end

    if (st.event_pending) begin
      st.hold_cnt = st.hold_cnt + 16'd1;
      if (st.hold_cnt >= regs.position_hold_ticks) begin
        st.event_pending = 1'b0;
        st.hold_cnt = '0;
        st.event_done = 1'b1;
        clear_touch_machine();
        hold_timeouts++;
      end
    end

    r.battery_removed = st.batt_low;
    r.is_raised = st.raised;
    r.is_fallen = st.fallen;
    r.raised_or_fell = st.event_pending;
    r.armed_stage = st.armed;
    id_requests += r.id_prompt_requests;
    learn_requests += r.learn_prompt_request;
    return r;
  endfunction

  // mostly runs of plausible pin activity, with some fully random noise
  function automatic item_t random_tick();
    item_t t;
    logic [18:0] raw;
    int b;
    int sel;
    if ($urandom_range(0, 15) == 0) begin
      raw = 19'($urandom);
      return item_t'(raw);
    end
    if (touch_run == 0 && $urandom_range(0, 4) == 0) touch_run = $urandom_range(1, 12);
    if (raise_run == 0 && $urandom_range(0, 9) == 0) raise_run = $urandom_range(1, 40);
    if (fall_run == 0 && $urandom_range(0, 9) == 0) fall_run = $urandom_range(1, 40);
    if (cut_run == 0 && $urandom_range(0, 24) == 0) cut_run = $urandom_range(1, 4);
    sel = $urandom_range(0, 2);
    t.sensor_enable = $urandom_range(0, 9) != 0;
    t.touch_pin = !(touch_run > 0 && sel != 1);
    t.horizontal_pin = !(touch_run > 0 && sel != 0);
    t.alarm_in_progress = $urandom_range(0, 11) == 0;
    t.flashing_busy = $urandom_range(0, 11) == 0;
    t.transmitter_enable = $urandom_range(0, 7) != 0;
    t.lock_wire_pin = !(cut_run > 0);
    t.raised_pin = !(raise_run > 0);
    t.fell_pin = !(fall_run > 0);
    if (touch_run > 0) touch_run--;
    if (raise_run > 0) raise_run--;
    if (fall_run > 0) fall_run--;
    if (cut_run > 0) cut_run--;
    if ($urandom_range(0, 2) == 0) begin
      b = $urandom_range(0, 1023);
    end else begin
      // hover around the threshold
      b = int'(regs.battery_low_threshold) + int'($urandom_range(0, 6)) - 3;
      if (b < 0) b = 0;
      if (b > 1023) b = 1023;
    end
    t.battery_level = 10'(b);
    return t;
  endfunction

  task automatic push_tick(input item_t t);
    pending_ticks.push_back(t);
    ticks_queued++;
  endtask

  task automatic push_random(input int n);
    repeat (n) push_tick(random_tick());
  endtask

  // waits for every queued tick to come back, then lets the result register settle
  task automatic drain();
    while (results_checked != ticks_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // keeps cfg_valid high across back-to-back writes; the caller lowers it
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegFirstTouch:    regs.first_touch_ticks = val[7:0];
      RegSecondTouch:   regs.second_touch_ticks = val[7:0];
      RegTouchWindow:   regs.touch_window_ticks = val;
      RegPosEnable:     regs.position_enable = val[0];
      RegPosQualify:    regs.position_qualify_ticks = val[7:0];
      RegPosHold:       regs.position_hold_ticks = val;
      RegBatteryThresh: regs.battery_low_threshold = val[9:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic report_fault(input string msg);
    mismatches++;
    if (mismatches <= MaxReported) $display("%t: %s", $realtime, msg);
  endtask

  function automatic string fmt_result(result_t r);
    return $sformatf("id=%0d learn=%0b stolen=%0b restored=%0b batt=%0b raised=%0b fallen=%0b evt=%0b armed=%0b",
                     r.id_prompt_requests, r.learn_prompt_request, r.stolen_alarm_start,
                     r.wire_restored, r.battery_removed, r.is_raised, r.is_fallen,
                     r.raised_or_fell, r.armed_stage);
  endfunction

  // sender: bursts with random gaps, plus the odd pause until all results are back
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_results.push_back(qualify_tick(in_flight));
      if (!s_tvalid || s_tready) begin
        if (!draining && $urandom_range(0, 299) == 0) draining = 1'b1;
        if (draining && expected_results.size() == 0) draining = 1'b0;
        if (draining || gap_left > 0 || pending_ticks.size() == 0) begin
          if (gap_left > 0 && !draining) gap_left--;
          s_tvalid <= 1'b0;
        end else begin
          in_flight = pending_ticks.pop_front();
          s_tdata <= {5'd0, in_flight.fell_pin, in_flight.raised_pin, in_flight.battery_level,
                      in_flight.lock_wire_pin, in_flight.transmitter_enable,
                      in_flight.flashing_busy, in_flight.alarm_in_progress,
                      in_flight.horizontal_pin, in_flight.touch_pin, in_flight.sensor_enable};
          s_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // receiver: checks each result, then picks the next ready from the current stall mode
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.id_prompt_requests = m_tdata[1:0];
        got.learn_prompt_request = m_tdata[2];
        got.stolen_alarm_start = m_tdata[3];
        got.wire_restored = m_tdata[4];
        got.battery_removed = m_tdata[5];
        got.is_raised = m_tdata[6];
        got.is_fallen = m_tdata[7];
        got.raised_or_fell = m_tdata[8];
        got.armed_stage = m_tdata[9];
        if (expected_results.size() == 0) begin
          report_fault($sformatf("result with nothing pending: %s", fmt_result(got)));
        end else begin
          want = expected_results.pop_front();
          if (got.id_prompt_requests !== want.id_prompt_requests ||
              got.learn_prompt_request !== want.learn_prompt_request ||
              got.stolen_alarm_start !== want.stolen_alarm_start ||
              got.wire_restored !== want.wire_restored ||
              got.battery_removed !== want.battery_removed ||
              got.is_raised !== want.is_raised ||
              got.is_fallen !== want.is_fallen ||
              got.raised_or_fell !== want.raised_or_fell ||
              got.armed_stage !== want.armed_stage)
            report_fault($sformatf("result %0d mismatch\n  expected %s\n  actual   %s",
                                   results_checked, fmt_result(want), fmt_result(got)));
        end
        results_checked++;
      end
      stall_phase++;
      if (stall_phase % 256 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 3) != 0;
        2: m_tready <= (stall_phase % 7) >= 3;
        default: m_tready <= $urandom_range(0, 9) == 0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no handshake for %0d cycles, %0d of %0d results back",
               idle_cycles, results_checked, ticks_queued);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    regs = '{first_touch_ticks: FirstTouchReset, second_touch_ticks: SecondTouchReset,
             touch_window_ticks: TouchWindowReset, position_enable: 1'b0,
             position_qualify_ticks: PosQualifyReset, position_hold_ticks: PosHoldReset,
             battery_low_threshold: BatteryThreshReset};
    st = '{default: 0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: sensor gating, blockers, double id request, battery edges
    push_tick(item_t'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 1'b0});
    push_tick(item_t'{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 10'd1023, 1'b1, 1'b1});
    push_tick(item_t'{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 10'd0, 1'b1, 1'b1});
    push_tick(item_t'{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 10'd0, 1'b1, 1'b1});
    push_tick(item_t'{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 10'd300, 1'b1, 1'b1});
    push_tick(item_t'{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 10'd255, 1'b1, 1'b1});
    push_tick(item_t'{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 10'd256, 1'b1, 1'b1});
    push_tick(item_t'{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 10'd512, 1'b1, 1'b1});
    push_tick(item_t'{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 10'd0, 1'b1, 1'b1});
    // first touch and wire restore together
    push_tick(item_t'{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 10'd700, 1'b1, 1'b1});
    push_tick(item_t'{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 10'd100, 1'b1, 1'b1});
    push_tick(item_t'{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 10'd900, 1'b1, 1'b1});
    // position pins do nothing while qualification is off
    push_tick(item_t'{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 10'd900, 1'b0, 1'b0});
    push_tick(item_t'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 10'd0, 1'b0, 1'b0});
    push_random(130);
    drain();

    // short window, position qualification on, highest battery threshold
    write_reg(RegFirstTouch, 16'd1);
    write_reg(RegSecondTouch, 16'd2);
    write_reg(RegTouchWindow, 16'd6);
    write_reg(RegPosEnable, 16'd1);
    write_reg(RegPosQualify, 16'd3);
    write_reg(RegPosHold, 16'd65535);
    write_reg(RegBatteryThresh, 16'd1023);
    write_reg(RegNoSuch, 16'hffff);
    cfg_valid <= 1'b0;
    push_random(220);
    drain();

    // widest touch counts, qualify on wrap to zero, battery threshold zero
    write_reg(RegFirstTouch, 16'd255);
    write_reg(RegSecondTouch, 16'd255);
    write_reg(RegTouchWindow, 16'd65535);
    write_reg(RegPosQualify, 16'd0);
    write_reg(RegBatteryThresh, 16'd0);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 260; i++)
      push_tick(item_t'{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
                        10'($urandom_range(0, 1023)), 1'b0, 1'b1});
    push_random(60);
    drain();

    // steady fell pin across a counter wrap; short hold fires the one-time event timeout
    write_reg(RegFirstTouch, 16'ha503);
    write_reg(RegSecondTouch, 16'd1);
    write_reg(RegTouchWindow, 16'd20);
    write_reg(RegPosQualify, 16'd10);
    write_reg(RegPosHold, 16'd40);
    write_reg(RegBatteryThresh, 16'd512);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 270; i++)
      push_tick(item_t'{1'b1, 1'b1, logic'(i % 9 >= 4), 1'b0, 1'b0, 1'b1, 1'b1,
                        10'($urandom_range(500, 524)), 1'b1, 1'b0});
    push_random(220);
    drain();

    // zero touch thresholds and zero touch window
    write_reg(RegFirstTouch, 16'd0);
    write_reg(RegSecondTouch, 16'd0);
    write_reg(RegTouchWindow, 16'd0);
    cfg_valid <= 1'b0;
    push_random(150);
    drain();

    // position qualification off again, hold register set to 1
    write_reg(RegFirstTouch, 16'd2);
    write_reg(RegSecondTouch, 16'd3);
    write_reg(RegTouchWindow, 16'd9);
    write_reg(RegPosEnable, 16'd0);
    write_reg(RegPosQualify, 16'd255);
    write_reg(RegPosHold, 16'd1);
    cfg_valid <= 1'b0;
    push_random(120);
    drain();

    $display("ran %0d ticks under six register settings (%0d register writes)",
             ticks_queued, reg_writes);
    $display("checked %0d results: %0d id requests, %0d learn requests, %0d hold timeouts",
             results_checked, id_requests, learn_requests, hold_timeouts);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures, %0d results still expected", mismatches, expected_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
